### rtl/periodic_edge_earliest_arrival_top_assert.svh
// Assertion macros for the earliest-arrival block checker.
// Used by pea_checker; expects clk and arst_n in scope.
`ifndef PERIODIC_EDGE_EARLIEST_ARRIVAL_TOP_ASSERT_SVH
`define PERIODIC_EDGE_EARLIEST_ARRIVAL_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PEA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PEA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/pea_pkg.sv
// Shared constants, codes, state types and heap interface structs
// for the periodic-edge earliest-arrival block. No dependencies.
package pea_pkg;

	localparam int MAX_NODES   = 1024;
	localparam int MAX_EDGES   = 8192;
	localparam int QUEUE_DEPTH = 16384;

	localparam int NODE_W  = $clog2(MAX_NODES);
	localparam int EDGE_W  = $clog2(MAX_EDGES);
	localparam int HEAD_W  = EDGE_W + 1;
	localparam int QIDX_W  = $clog2(QUEUE_DEPTH);
	localparam int QSIZE_W = QIDX_W + 1;
	localparam int CH_W    = QIDX_W + 2;
	localparam int TIME_W  = 16;
	localparam int PER_W   = 16;
	localparam int DELAY_W = 8;
	localparam int CFG_W   = 16;
	localparam int SUM_W   = TIME_W + 1;
	localparam int ARR_W   = TIME_W + 2;
	localparam int KEY_W   = TIME_W + NODE_W;
	localparam int CLR_W   = NODE_W + 1;
	localparam int CNT_W   = $clog2(SUM_W + 1);

	localparam logic [DELAY_W-1:0] DELAY_RESET = 8'd3;
	localparam logic [TIME_W-1:0]  LIMIT_RESET = 16'd4096;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_SEED = 2'd1;
	localparam logic [1:0] KIND_RUN  = 2'd2;

	localparam logic CFG_DELAY = 1'b0;
	localparam logic CFG_LIMIT = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_LD_RD, S_LD_WR, S_OF_RD, S_OF_CHK, S_OF_WAIT,
		S_RUN_TOP, S_POP_WAIT, S_RUN_CHK, S_RUN_HEAD, S_EDGE_TOP, S_EDGE_RD,
		S_DIV_WAIT, S_RESULT
	} top_state_t;

	typedef enum logic [3:0] {
		H_IDLE, H_PUSH_UP, H_PUSH_CMP, H_POP_TOP, H_POP_LAST, H_POP_C,
		H_POP_C0, H_POP_C1, H_POP_CMP, H_POP_END
	} heap_state_t;

	typedef struct packed {
		logic             push;
		logic             pop;
		logic [KEY_W-1:0] key;
	} heap_req_t;

	typedef struct packed {
		logic               busy;
		logic [KEY_W-1:0]   top;
		logic [QSIZE_W-1:0] size;
	} heap_rsp_t;

endpackage

### rtl/pea_rem.sv
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on pea_pkg.
module pea_rem import pea_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [PER_W-1:0] divisor,
	output logic             busy,
	output logic [PER_W-1:0] rem
);

	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] dvd_q;
	logic [PER_W-1:0] div_q;
	logic [PER_W-1:0] rem_q;
	logic [SUM_W-1:0] trial;

	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign busy  = (cnt_q != '0);
	assign rem   = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(SUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy) begin
			dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
			// subtract when the partial remainder reaches the divisor
			if (trial >= {1'b0, div_q}) begin
				rem_q <= PER_W'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[PER_W-1:0];
			end
		end
	end

endmodule

### rtl/pea_heap.sv
// Binary min-heap of (time, node) keys held in one synchronous memory.
// Push sifts up, pop sifts down, one memory read per step. Depends on pea_pkg.
module pea_heap import pea_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  heap_req_t req,
	output heap_rsp_t rsp
);

	logic [KEY_W-1:0]   mem [QUEUE_DEPTH];
	heap_state_t        state_q, state_d;
	logic [QSIZE_W-1:0] size_q;
	logic [QIDX_W-1:0]  i_q, cidx_q, up;
	logic [KEY_W-1:0]   key_q, top_q, last_q, cval_q, rdata;
	logic [CH_W-1:0]    c, c1;
	logic [QIDX_W-1:0]  raddr, waddr;
	logic               wen;
	logic [KEY_W-1:0]   wdata;

	assign c  = {1'b0, i_q, 1'b1};
	assign c1 = c + 1'b1;
	assign up = QIDX_W'((i_q - 1'b1) >> 1);

	assign rsp.busy = (state_q != H_IDLE);
	assign rsp.top  = top_q;
	assign rsp.size = size_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			H_IDLE: begin
				if (req.push && size_q < QSIZE_W'(QUEUE_DEPTH)) begin
					state_d = H_PUSH_UP;
				end else if (req.pop && size_q != '0) begin
					state_d = H_POP_TOP;
				end
			end
			H_PUSH_UP:  state_d = (i_q == '0) ? H_IDLE : H_PUSH_CMP;
			H_PUSH_CMP: state_d = (rdata <= key_q) ? H_IDLE : H_PUSH_UP;
			H_POP_TOP:  state_d = H_POP_LAST;
			H_POP_LAST: state_d = H_POP_C;
			H_POP_C:    state_d = (c >= CH_W'(size_q)) ? H_POP_END : H_POP_C0;
			H_POP_C0:   state_d = (c1 < CH_W'(size_q)) ? H_POP_C1 : H_POP_CMP;
			H_POP_C1:   state_d = H_POP_CMP;
			H_POP_CMP:  state_d = (last_q <= cval_q) ? H_POP_END : H_POP_C;
			H_POP_END:  state_d = H_IDLE;
			default:    state_d = H_IDLE;
		endcase
	end

	always_comb begin
		raddr = '0;
		wen   = 1'b0;
		waddr = i_q;
		wdata = key_q;
		case (state_q)
			H_PUSH_UP: begin
				raddr = up;
				wen   = (i_q == '0);
			end
			H_PUSH_CMP: begin
				wen   = 1'b1;
				wdata = (rdata <= key_q) ? key_q : rdata;
			end
			H_POP_TOP: raddr = QIDX_W'(size_q - 1'b1);
			H_POP_C:   raddr = c[QIDX_W-1:0];
			H_POP_C0:  raddr = c1[QIDX_W-1:0];
			H_POP_CMP: begin
				wen   = !(last_q <= cval_q);
				wdata = cval_q;
			end
			H_POP_END: begin
				wen   = (size_q != '0);
				wdata = last_q;
			end
			default: raddr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			size_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == H_IDLE && state_d == H_PUSH_UP) begin
				size_q <= size_q + 1'b1;
			end else if (state_q == H_POP_TOP) begin
				size_q <= size_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			H_IDLE: begin
				key_q <= req.key;
				i_q   <= size_q[QIDX_W-1:0];
			end
			H_PUSH_CMP: begin
				if (!(rdata <= key_q)) begin
					i_q <= up;
				end
			end
			H_POP_TOP:  top_q <= rdata;
			H_POP_LAST: begin
				last_q <= rdata;
				i_q    <= '0;
			end
			H_POP_C0: begin
				cval_q <= rdata;
				cidx_q <= c[QIDX_W-1:0];
			end
			H_POP_C1: begin
				// take the right child only when strictly smaller
				if (rdata < cval_q) begin
					cval_q <= rdata;
					cidx_q <= c1[QIDX_W-1:0];
				end
			end
			H_POP_CMP: begin
				if (!(last_q <= cval_q)) begin
					i_q <= cidx_q;
				end
			end
			default: i_q <= i_q;
		endcase
	end

endmodule

### rtl/periodic_edge_earliest_arrival_top.sv
// Top level of the periodic-edge earliest-arrival block: sequencer, edge,
// list-head and per-node memories. Uses pea_pkg, pea_heap and pea_rem.
//
// Usage: items enter on the in channel (valid/ready). A load item appends an
// edge to its source node's list; a seed item offers its node at time 0,
// followed by the heap sift-up. A run item pops the heap until it is empty;
// each settled node walks its edge list, and each edge runs the bit-serial
// remainder that rounds up to the next departure, then the sift-up; each pop
// sifts down through the heap. The run then returns one transaction on the
// out channel and clears the per-node memory.
// in_ready is high only when the sequencer is idle, one item at a time.
// The result sits in an output register; a stalled receiver holds it, and
// only the next run waits for the register to drain.
// Reset starts a clearing pass over all MAX_NODES (1024) entries of the
// list-head and per-node memories; no item is accepted during it, while
// configuration writes are taken at any time.
module periodic_edge_earliest_arrival_top import pea_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic [NODE_W-1:0]  node,
	input  logic [NODE_W-1:0]  neighbor,
	input  logic [PER_W-1:0]   period,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [TIME_W-1:0]  latest_time,
	output logic               none_reached,
	input  logic               cfg_wen,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	localparam int EDGE_WORD = NODE_W + PER_W + HEAD_W;
	localparam int NODE_WORD = TIME_W + 1;

	logic [HEAD_W-1:0]    head_mem [MAX_NODES];
	logic [NODE_WORD-1:0] node_mem [MAX_NODES];
	logic [EDGE_WORD-1:0] edge_mem [MAX_EDGES];

	top_state_t          state_q, state_d;
	logic [CLR_W-1:0]    clr_cnt_q;
	logic                clr_head_q;
	logic [DELAY_W-1:0]  delay_q;
	logic [TIME_W-1:0]   limit_q;
	logic [HEAD_W-1:0]   edges_q;
	logic                ret_run_q;
	logic                none_q;
	logic [TIME_W-1:0]   latest_q;
	logic                out_valid_q;
	logic [TIME_W-1:0]   out_latest_q;
	logic                out_none_q;
	logic [NODE_W-1:0]   node_q, nb_q, of_v_q, cur_v_q;
	logic [PER_W-1:0]    per_q, p_q;
	logic [ARR_W-1:0]    of_t_q;
	logic [TIME_W-1:0]   cur_t_q;
	logic [HEAD_W-1:0]   h_q;
	logic [SUM_W-1:0]    s_q;

	logic [NODE_W-1:0]    head_addr, node_addr;
	logic                 head_we, node_we, edge_we;
	logic [HEAD_W-1:0]    head_wd, head_rd;
	logic [NODE_WORD-1:0] node_wd, node_rd;
	logic [EDGE_W-1:0]    edge_addr;
	logic [EDGE_WORD-1:0] edge_wd, edge_rd;

	heap_req_t           hreq;
	heap_rsp_t           hrsp;
	logic                rem_start, rem_busy;
	logic [SUM_W-1:0]    rem_dvd;
	logic [PER_W-1:0]    rem_div, rem_val;

	logic                in_acc, out_free, heap_full, of_drop, edge_ok, settle;
	logic [NODE_W-1:0]   e_target;
	logic [PER_W-1:0]    e_period;
	logic [HEAD_W-1:0]   e_link;
	top_state_t          ret_state;

	assign in_ready     = (state_q == S_IDLE);
	assign in_acc       = in_valid && in_ready;
	assign out_valid    = out_valid_q;
	assign latest_time  = out_latest_q;
	assign none_reached = out_none_q;
	assign out_free     = !out_valid_q || out_ready;

	assign {e_target, e_period, e_link} = edge_rd;
	assign heap_full = (hrsp.size >= QSIZE_W'(QUEUE_DEPTH));
	assign of_drop   = (of_t_q >= ARR_W'(limit_q))
		|| (node_rd[TIME_W] && of_t_q >= ARR_W'(node_rd[TIME_W-1:0]))
		|| heap_full;
	assign edge_ok   = (h_q != '0) && (h_q <= HEAD_W'(MAX_EDGES));
	assign settle    = node_rd[TIME_W] && (node_rd[TIME_W-1:0] == cur_t_q);
	assign ret_state = ret_run_q ? S_EDGE_TOP : S_IDLE;

	pea_heap u_heap (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hreq),
		.rsp    (hrsp)
	);

	pea_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (rem_dvd),
		.divisor  (rem_div),
		.busy     (rem_busy),
		.rem      (rem_val)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_cnt_q == CLR_W'(MAX_NODES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_acc) begin
					case (kind)
						KIND_LOAD: state_d = S_LD_RD;
						KIND_SEED: state_d = S_OF_RD;
						KIND_RUN:  state_d = S_RUN_TOP;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_LD_RD:    state_d = S_LD_WR;
			S_LD_WR:    state_d = S_IDLE;
			S_OF_RD:    state_d = S_OF_CHK;
			S_OF_CHK:   state_d = of_drop ? ret_state : S_OF_WAIT;
			S_OF_WAIT:  state_d = hrsp.busy ? S_OF_WAIT : ret_state;
			S_RUN_TOP:  state_d = (hrsp.size == '0) ? S_RESULT : S_POP_WAIT;
			S_POP_WAIT: state_d = hrsp.busy ? S_POP_WAIT : S_RUN_CHK;
			S_RUN_CHK:  state_d = settle ? S_RUN_HEAD : S_RUN_TOP;
			S_RUN_HEAD: state_d = S_EDGE_TOP;
			S_EDGE_TOP: state_d = edge_ok ? S_EDGE_RD : S_RUN_TOP;
			S_EDGE_RD:  state_d = S_DIV_WAIT;
			S_DIV_WAIT: state_d = rem_busy ? S_DIV_WAIT : S_OF_RD;
			S_RESULT:   state_d = out_free ? S_CLEAR : S_RESULT;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		head_addr = node_q;
		head_we   = 1'b0;
		head_wd   = edges_q + 1'b1;
		node_addr = of_v_q;
		node_we   = 1'b0;
		node_wd   = {1'b1, of_t_q[TIME_W-1:0]};
		edge_addr = edges_q[EDGE_W-1:0];
		edge_we   = 1'b0;
		edge_wd   = {nb_q, per_q, head_rd};
		hreq.push = 1'b0;
		hreq.pop  = 1'b0;
		hreq.key  = {of_t_q[TIME_W-1:0], of_v_q};
		rem_start = 1'b0;
		rem_dvd   = SUM_W'(cur_t_q) + SUM_W'(delay_q);
		rem_div   = (e_period == '0) ? PER_W'(1) : e_period;
		case (state_q)
			S_CLEAR: begin
				node_addr = clr_cnt_q[NODE_W-1:0];
				node_we   = 1'b1;
				node_wd   = '0;
				head_addr = clr_cnt_q[NODE_W-1:0];
				head_we   = clr_head_q;
				head_wd   = '0;
			end
			S_LD_WR: begin
				edge_we = (edges_q < HEAD_W'(MAX_EDGES));
				head_we = edge_we;
			end
			S_OF_CHK: begin
				hreq.push = !of_drop;
				node_we   = !of_drop;
			end
			S_RUN_TOP:  hreq.pop = (hrsp.size != '0);
			S_POP_WAIT: node_addr = hrsp.top[NODE_W-1:0];
			S_RUN_CHK:  head_addr = cur_v_q;
			S_EDGE_TOP: edge_addr = EDGE_W'(h_q - 1'b1);
			S_EDGE_RD:  rem_start = 1'b1;
			default:    head_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_addr] <= head_wd;
		end
		head_rd <= head_mem[head_addr];
	end

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_addr] <= node_wd;
		end
		node_rd <= node_mem[node_addr];
	end

	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edge_addr] <= edge_wd;
		end
		edge_rd <= edge_mem[edge_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			clr_head_q  <= 1'b1;
			delay_q     <= DELAY_RESET;
			limit_q     <= LIMIT_RESET;
			edges_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) begin
				case (cfg_index)
					CFG_DELAY: delay_q <= cfg_data[DELAY_W-1:0];
					CFG_LIMIT: limit_q <= cfg_data[TIME_W-1:0];
					default:   delay_q <= delay_q;
				endcase
			end
			if (state_q == S_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end else if (state_q == S_RESULT) begin
				clr_cnt_q  <= '0;
				clr_head_q <= 1'b0;
			end
			if (edge_we) begin
				edges_q <= edges_q + 1'b1;
			end
			// load the result, or drop it once taken
			if (state_q == S_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESULT && out_free) begin
			out_latest_q <= latest_q;
			out_none_q   <= none_q;
		end
		case (state_q)
			S_IDLE: begin
				node_q    <= node;
				nb_q      <= neighbor;
				per_q     <= period;
				of_v_q    <= node;
				of_t_q    <= '0;
				ret_run_q <= 1'b0;
				none_q    <= (hrsp.size == '0);
				latest_q  <= '0;
			end
			S_POP_WAIT: begin
				cur_v_q <= hrsp.top[NODE_W-1:0];
				cur_t_q <= hrsp.top[KEY_W-1:NODE_W];
			end
			S_RUN_CHK: begin
				if (settle && cur_t_q > latest_q) begin
					latest_q <= cur_t_q;
				end
			end
			S_RUN_HEAD: h_q <= head_rd;
			S_EDGE_RD: begin
				of_v_q <= e_target;
				h_q    <= e_link;
				s_q    <= rem_dvd;
				p_q    <= rem_div;
			end
			S_DIV_WAIT: begin
				// round up to the next departure
				if (rem_val != '0) begin
					of_t_q <= ARR_W'(s_q) + ARR_W'(p_q - rem_val);
				end else begin
					of_t_q <= ARR_W'(s_q);
				end
				ret_run_q <= 1'b1;
			end
			default: h_q <= h_q;
		endcase
	end

endmodule

### rtl/pea_checker.sv
// Port-level checker for the earliest-arrival block, bound to the top level.
// Depends on pea_pkg and periodic_edge_earliest_arrival_top_assert.svh.
`include "periodic_edge_earliest_arrival_top_assert.svh"

module pea_checker import pea_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [1:0]        kind,
	input logic              out_valid,
	input logic              out_ready,
	input logic [TIME_W-1:0] latest_time,
	input logic              none_reached
);

	`PEA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(latest_time) && $stable(none_reached), "result changed while stalled")
	`PEA_ASSERT_NOW(a_none_zero, out_valid && none_reached, latest_time == '0, "empty run reports a nonzero time")
	`PEA_ASSERT_NEXT(a_run_busy, in_valid && in_ready && kind == KIND_RUN, !in_ready, "ready right after a run transaction")
	`PEA_ASSERT_NEXT(a_load_busy, in_valid && in_ready && kind == KIND_LOAD, !in_ready && !out_valid || !in_ready, "ready right after a load transaction")

endmodule

bind periodic_edge_earliest_arrival_top pea_checker u_pea_checker (.*);
